[design/hsc_pkg.sv]
package hsc_pkg;

  // Syndrome width and check word layout
  localparam int unsigned SYN_W   = 9;
  localparam int unsigned CHECK_W = SYN_W + 1;
  localparam logic [SYN_W-1:0] SYN_MASK = 9'h1FF;

  // Byte counter width and the number of byte slots it can address
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned ROM_ROWS = 1 << CNT_W;
  localparam int unsigned IDX_W    = CNT_W + 3;

  typedef enum logic [1:0] {
    STATUS_CLEAN    = 2'd0,
    STATUS_SINGLE   = 2'd1,
    STATUS_DOUBLE   = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_e;

  // Hamming positions of the eight data bits of each record byte
  typedef logic [ROM_ROWS-1:0][7:0][SYN_W-1:0] pos_rom_t;

  // Record summary after the current byte has been folded in
  typedef struct packed {
    logic [SYN_W-1:0] syndrome;
    logic             data_parity;
    logic [CNT_W-1:0] byte_count;
    logic             overlength;
  } acc_sum_t;

  // One result item
  typedef struct packed {
    logic [CHECK_W-1:0] check_word;
    status_e            status;
    logic               fix_valid;
    logic [CNT_W-1:0]   fix_byte_index;
    logic [2:0]         fix_bit_index;
  } result_t;

  // Position table, built at elaboration: data bit d skips every power of two
  function automatic pos_rom_t build_pos_rom();
    pos_rom_t    rom;
    int unsigned d;
    int unsigned p;
    int unsigned k;
    rom = '0;
    for (int unsigned n = 0; n < ROM_ROWS; n++) begin
      for (int unsigned b = 0; b < 8; b++) begin
        d = n * 8 + b;
        p = d + 1;
        k = 1;
        while (k <= p) begin
          p = p + 1;
          k = k << 1;
        end
        rom[n][b] = SYN_W'(p);
      end
    end
    return rom;
  endfunction

  localparam pos_rom_t POS_ROM = build_pos_rom();

endpackage

[design/hsc_in_if.sv]
interface hsc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [9:0] stored_check;

  modport source (output valid, mode, data_byte, last_byte, stored_check, input ready);
  modport sink   (input valid, mode, data_byte, last_byte, stored_check, output ready);
endinterface

[design/hsc_out_if.sv]
interface hsc_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] check_word;
  logic [1:0] status;
  logic       fix_valid;
  logic [5:0] fix_byte_index;
  logic [2:0] fix_bit_index;

  modport source (output valid, check_word, status, fix_valid, fix_byte_index,
                  fix_bit_index, input ready);
  modport sink   (input valid, check_word, status, fix_valid, fix_byte_index,
                  fix_bit_index, output ready);
endinterface

[design/hsc_accum.sv]
module hsc_accum #(
  parameter int unsigned MAX_BYTES = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output hsc_pkg::acc_sum_t   sum_o
);

  logic [hsc_pkg::SYN_W-1:0] syn_q, syn_d;
  logic                      par_q, par_d;
  logic [hsc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      ovl_q, ovl_d;

  logic                      full;
  logic [hsc_pkg::SYN_W-1:0] byte_syn;

  assign full = (cnt_q >= hsc_pkg::CNT_W'(MAX_BYTES));

  // XOR the positions of the set bits of this byte
  always_comb begin
    byte_syn = '0;
    for (int b = 0; b < 8; b++) begin
      if (data_byte_i[b]) begin
        byte_syn = byte_syn ^ hsc_pkg::POS_ROM[cnt_q][b];
      end
    end
  end

  // Summary including the current byte; a byte past the limit is dropped
  always_comb begin
    sum_o.syndrome    = full ? syn_q : ((syn_q ^ byte_syn) & hsc_pkg::SYN_MASK);
    sum_o.data_parity = full ? par_q : (par_q ^ (^data_byte_i));
    sum_o.byte_count  = full ? cnt_q : (cnt_q + hsc_pkg::CNT_W'(1));
    sum_o.overlength  = ovl_q | full;
  end

  // Accumulators restart after the last byte
  always_comb begin
    syn_d = syn_q;
    par_d = par_q;
    cnt_d = cnt_q;
    ovl_d = ovl_q;
    if (step_i) begin
      if (last_byte_i) begin
        syn_d = '0;
        par_d = 1'b0;
        cnt_d = '0;
        ovl_d = 1'b0;
      end else begin
        syn_d = sum_o.syndrome;
        par_d = sum_o.data_parity;
        cnt_d = sum_o.byte_count;
        ovl_d = sum_o.overlength;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syn_q <= '0;
      par_q <= 1'b0;
      cnt_q <= '0;
      ovl_q <= 1'b0;
    end else begin
      syn_q <= syn_d;
      par_q <= par_d;
      cnt_q <= cnt_d;
      ovl_q <= ovl_d;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> cnt_q == '0 && syn_q == '0 && !ovl_q && !par_q)
    else $error("accumulators not cleared after last byte");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hsc_pkg::CNT_W'(MAX_BYTES))
    else $error("byte count past record limit");
`endif

endmodule

[design/hsc_decode.sv]
module hsc_decode (
  input  hsc_pkg::acc_sum_t                sum_i,
  input  logic                             mode_i,
  input  logic [hsc_pkg::CHECK_W-1:0]      stored_check_i,
  output hsc_pkg::result_t                 result_o
);

  logic [hsc_pkg::SYN_W-1:0] ssyn;
  logic [hsc_pkg::SYN_W-1:0] err_syn;
  logic                      oerr;
  logic                      err_pow2;
  logic [3:0]                bit_len;
  logic [hsc_pkg::IDX_W-1:0] bit_idx;
  logic [hsc_pkg::IDX_W-1:0] data_bits;

  assign ssyn     = stored_check_i[hsc_pkg::SYN_W-1:0];
  assign err_syn  = sum_i.syndrome ^ ssyn;
  assign oerr     = sum_i.data_parity ^ (^ssyn) ^ stored_check_i[hsc_pkg::SYN_W];
  assign err_pow2 = ((err_syn & (err_syn - hsc_pkg::SYN_W'(1))) == '0);

  // Bit length of the error position = parity positions below it
  always_comb begin
    bit_len = '0;
    for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
      if (err_syn[i]) begin
        bit_len = 4'(i + 1);
      end
    end
  end

  assign bit_idx   = err_syn - hsc_pkg::SYN_W'(1) - hsc_pkg::SYN_W'(bit_len);
  assign data_bits = {sum_i.byte_count, 3'b000};

  // Classify the record
  always_comb begin
    result_o.check_word     = {sum_i.data_parity ^ (^sum_i.syndrome), sum_i.syndrome};
    result_o.status         = hsc_pkg::STATUS_CLEAN;
    result_o.fix_valid      = 1'b0;
    result_o.fix_byte_index = '0;
    result_o.fix_bit_index  = '0;
    if (sum_i.overlength) begin
      result_o.check_word = '0;
      result_o.status     = hsc_pkg::STATUS_TOO_LONG;
    end else if (mode_i) begin
      if (err_syn == '0 && !oerr) begin
        result_o.status = hsc_pkg::STATUS_CLEAN;
      end else if (oerr) begin
        result_o.status = hsc_pkg::STATUS_SINGLE;
        // no flip for parity-position errors or bits past the record
        if (!err_pow2 && bit_idx < data_bits) begin
          result_o.fix_valid      = 1'b1;
          result_o.fix_byte_index = bit_idx[hsc_pkg::IDX_W-1:3];
          result_o.fix_bit_index  = bit_idx[2:0];
        end
      end else begin
        result_o.status = hsc_pkg::STATUS_DOUBLE;
      end
    end
  end

endmodule

[design/hamming_secded_record_codec.sv]
// Hamming SECDED record codec. Record bytes enter on in_i, one transfer per
// byte, bit 0 first; each data bit takes the next Hamming position that is not
// a power of two. A byte with last_byte set closes the record and yields one
// transfer on out_o: in encode mode (mode 0) the 10-bit check word, in decode
// mode (mode 1) a comparison with stored_check reporting clean, a corrected
// single error (with the byte and bit to flip when it is a data bit inside the
// record), or a double error. Records longer than MAX_BYTES report too long.
// Bytes that are not last produce no output. Throughput is one byte per clock,
// save that a pending result holds a last byte: the byte goes through an input
// register, then the position table lookup, syndrome XOR and check logic
// combinationally into the result register, which presents the result on out_o.
// A pending result only stalls the next last byte; other bytes keep flowing.
module hamming_secded_record_codec #(
  parameter int unsigned MAX_BYTES = 60
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsc_in_if.sink     in_i,
  hsc_out_if.source  out_o
);

  // Input register
  logic                           in_valid_q;
  logic                           mode_q;
  logic [7:0]                     data_q;
  logic                           last_q;
  logic [hsc_pkg::CHECK_W-1:0]    stored_q;

  // Result register
  logic                           out_valid_q;
  hsc_pkg::result_t               res_q;

  hsc_pkg::acc_sum_t              sum;
  hsc_pkg::result_t               res;
  logic                           out_free;
  logic                           advance;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q   <= in_i.mode;
      data_q   <= in_i.data_byte;
      last_q   <= in_i.last_byte;
      stored_q <= in_i.stored_check;
    end
  end

  hsc_accum #(
    .MAX_BYTES (MAX_BYTES)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (data_q),
    .last_byte_i (last_q),
    .sum_o       (sum)
  );

  hsc_decode u_decode (
    .sum_i          (sum),
    .mode_i         (mode_q),
    .stored_check_i (stored_q),
    .result_o       (res)
  );

  // Result register loads when a last byte advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.check_word     = res_q.check_word;
  assign out_o.status         = res_q.status;
  assign out_o.fix_valid      = res_q.fix_valid;
  assign out_o.fix_byte_index = res_q.fix_byte_index;
  assign out_o.fix_bit_index  = res_q.fix_bit_index;

`ifndef SYNTH
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q && !out_o.ready) |-> $past(advance && last_q))
    else $error("result appeared without a last byte");

  a_fix_only_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fix_valid |-> res_q.status == hsc_pkg::STATUS_SINGLE)
    else $error("bit fix reported outside single-error status");

  a_too_long_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == hsc_pkg::STATUS_TOO_LONG
      |-> res_q.check_word == '0 && !res_q.fix_valid)
    else $error("overlong record carries check word or fix");

  a_fix_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q && res.fix_valid |-> res.fix_byte_index < sum.byte_count)
    else $error("fix location beyond record length");
`endif

endmodule

[verif/hamming_secded_record_codec_tb.sv]
module hamming_secded_record_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES    = 60;
  localparam int unsigned RAND_BYTES   = 800;
  localparam int unsigned MIN_RECORDS  = 40;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Ways a decode record gets damaged before it goes in
  typedef enum int {
    FLAW_NONE,
    FLAW_DATA_BIT,
    FLAW_CHECK_BIT,
    FLAW_PARITY_BIT,
    FLAW_PAST_DATA,
    FLAW_DOUBLE,
    FLAW_GARBAGE
  } flaw_e;

  // Running record state, mirrors the block's accumulators
  typedef struct packed {
    logic [hsc_pkg::SYN_W-1:0] syn;
    logic                      dpar;
    logic [hsc_pkg::CNT_W-1:0] cnt;
    logic                      ovl;
  } record_acc_t;

  typedef struct {
    logic       mode;
    logic [7:0] data;
    logic       last;
    logic [9:0] stored;
  } byte_xfer_t;

  logic clk = 1'b0;
  logic rst_n;

  hsc_in_if  in_if ();
  hsc_out_if out_if ();

  hamming_secded_record_codec #(
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  byte_xfer_t        pending_bytes[$];
  hsc_pkg::result_t  predicted_reports[$];
  record_acc_t       record_acc;
  byte_xfer_t        next_byte;
  hsc_pkg::result_t  want;

  int unsigned total_bytes    = 1;
  int unsigned bytes_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned phase;
  int unsigned send_idle;
  int unsigned recv_idle;
  logic        in_taken = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hamming position of data bit n: skip every power of two on the way
  function automatic int unsigned hamming_pos(int unsigned bit_idx);
    int unsigned p;
    p = bit_idx + 1;
    for (int unsigned pw = 1; pw <= p; pw = pw << 1) p++;
    return p;
  endfunction

  function automatic record_acc_t fold_byte(record_acc_t a, logic [7:0] d);
    if (a.cnt >= MAX_BYTES) begin
      a.ovl = 1'b1;
    end else begin
      for (int b = 0; b < 8; b++) begin
        if (d[b]) begin
          a.syn  = a.syn ^ hsc_pkg::SYN_W'(hamming_pos(int'(a.cnt) * 8 + b));
          a.dpar = ~a.dpar;
        end
      end
      a.cnt = a.cnt + 1'b1;
    end
    return a;
  endfunction

  function automatic logic [hsc_pkg::CHECK_W-1:0] check_word_of(record_acc_t a);
    return {a.dpar ^ (^a.syn), a.syn};
  endfunction

  // Report the block should give when a record closes
  function automatic hsc_pkg::result_t judge_record(record_acc_t a, logic dec,
                                                    logic [9:0] stored);
    hsc_pkg::result_t          r;
    logic [hsc_pkg::SYN_W-1:0] err;
    logic                      oerr;
    int unsigned               idx;
    r = '0;
    if (a.ovl) begin
      r.status = hsc_pkg::STATUS_TOO_LONG;
    end else begin
      r.check_word = check_word_of(a);
      if (dec) begin
        err  = a.syn ^ stored[hsc_pkg::SYN_W-1:0];
        oerr = a.dpar ^ (^stored[hsc_pkg::SYN_W-1:0]) ^ stored[hsc_pkg::SYN_W];
        if (err == '0 && !oerr) begin
          r.status = hsc_pkg::STATUS_CLEAN;
        end else if (oerr) begin
          r.status = hsc_pkg::STATUS_SINGLE;
          // only a data position inside the record gets a flip
          if (err != '0 && (err & (err - 1'b1)) != '0) begin
            idx = int'(err) - 1 - $clog2(int'(err));
            if (idx < int'(a.cnt) * 8) begin
              r.fix_valid      = 1'b1;
              r.fix_byte_index = hsc_pkg::CNT_W'(idx >> 3);
              r.fix_bit_index  = 3'(idx & 7);
            end
          end
        end else begin
          r.status = hsc_pkg::STATUS_DOUBLE;
        end
      end
    end
    return r;
  endfunction

  // Queue one record; decode records are damaged as asked, in a data byte or the stored word
  task automatic queue_record(input logic [7:0] body[$], input logic dec, input flaw_e flaw);
    record_acc_t a;
    logic [9:0]  stored;
    logic [8:0]  v;
    logic [7:0]  sent[$];
    int unsigned nbits;
    int unsigned i;
    int unsigned j;
    int unsigned p;
    int unsigned pick;
    byte_xfer_t  x;
    a = '0;
    foreach (body[k]) a = fold_byte(a, body[k]);
    stored = check_word_of(a);
    sent   = body;
    nbits  = int'(a.cnt) * 8;
    case (flaw)
      FLAW_DATA_BIT: begin
        i = $urandom_range(nbits - 1);
        sent[i / 8] = sent[i / 8] ^ 8'(1 << (i % 8));
      end
      FLAW_CHECK_BIT: begin
        i = $urandom_range(hsc_pkg::SYN_W - 1);
        stored[i] = ~stored[i];
      end
      FLAW_PARITY_BIT: begin
        stored[hsc_pkg::SYN_W] = ~stored[hsc_pkg::SYN_W];
      end
      FLAW_PAST_DATA: begin
        p = hamming_pos(nbits + $urandom_range(7));
        if (p < (1 << hsc_pkg::SYN_W)) begin
          v = 9'(p);
          stored[hsc_pkg::SYN_W-1:0] = stored[hsc_pkg::SYN_W-1:0] ^ v;
          stored[hsc_pkg::SYN_W]     = stored[hsc_pkg::SYN_W] ^ ~(^v);
        end
      end
      FLAW_DOUBLE: begin
        i = $urandom_range(nbits + hsc_pkg::CHECK_W - 1);
        do j = $urandom_range(nbits + hsc_pkg::CHECK_W - 1); while (j == i);
        for (int n = 0; n < 2; n++) begin
          pick = (n == 0) ? i : j;
          if (pick < nbits) sent[pick / 8] = sent[pick / 8] ^ 8'(1 << (pick % 8));
          else stored[pick - nbits] = ~stored[pick - nbits];
        end
      end
      FLAW_GARBAGE: begin
        stored = 10'($urandom_range(1023));
      end
      default: ;
    endcase
    if (!dec) stored = 10'($urandom_range(1023));
    foreach (sent[k]) begin
      x.last   = (k == sent.size() - 1);
      x.data   = sent[k];
      x.mode   = x.last ? dec : 1'($urandom_range(1));
      x.stored = x.last ? stored : 10'($urandom_range(1023));
      pending_bytes.push_back(x);
    end
  endtask

  // Input side: track transfers and predict the report of each record
  always @(posedge clk) begin
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      bytes_accepted++;
      record_acc = fold_byte(record_acc, in_if.data_byte);
      if (in_if.last_byte) begin
        predicted_reports.push_back(judge_record(record_acc, in_if.mode,
                                                 in_if.stored_check));
        record_acc = '0;
      end
    end
  end

  // Output side: compare each report with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_reports.size() == 0) begin
        $error("report with none pending: check_word %h status %0d",
               out_if.check_word, out_if.status);
        mismatch_count++;
      end else begin
        want = predicted_reports.pop_front();
        if (out_if.check_word !== want.check_word) begin
          $error("check_word: expected %h, got %h", want.check_word, out_if.check_word);
          mismatch_count++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatch_count++;
        end
        if (out_if.fix_valid !== want.fix_valid) begin
          $error("fix_valid: expected %0d, got %0d", want.fix_valid, out_if.fix_valid);
          mismatch_count++;
        end
        if (out_if.fix_byte_index !== want.fix_byte_index) begin
          $error("fix_byte_index: expected %0d, got %0d",
                 want.fix_byte_index, out_if.fix_byte_index);
          mismatch_count++;
        end
        if (out_if.fix_bit_index !== want.fix_bit_index) begin
          $error("fix_bit_index: expected %0d, got %0d",
                 want.fix_bit_index, out_if.fix_bit_index);
          mismatch_count++;
        end
      end
    end
  end

  // Driver: new byte or idle once the previous one is taken; random receiver stalls
  always @(negedge clk) begin
    if (rst_n) begin
      phase = (bytes_accepted * 3) / total_bytes;
      case (phase)
        0:       begin send_idle = 24; recv_idle = 88; end
        1:       begin send_idle = 88; recv_idle = 24; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      if (!in_if.valid || in_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_byte = pending_bytes.pop_front();
          in_if.mode         <= next_byte.mode;
          in_if.data_byte    <= next_byte.data;
          in_if.last_byte    <= next_byte.last;
          in_if.stored_check <= next_byte.stored;
          in_if.valid        <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: too long without any transfer means the block is stuck
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[hamming_secded_record_codec] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [7:0]  body[$];
    int unsigned len;
    int unsigned sel;
    int unsigned records;
    logic        dec;
    flaw_e       flaw;

    rst_n              = 1'b0;
    record_acc         = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = 1'b0;
    in_if.data_byte    = '0;
    in_if.last_byte    = 1'b0;
    in_if.stored_check = '0;
    out_if.ready       = 1'b0;

    // Directed: data extremes, encode, every decode outcome but too long, short multi-byte records
    queue_record('{8'h00}, 1'b0, FLAW_NONE);
    queue_record('{8'hFF}, 1'b0, FLAW_NONE);
    queue_record('{8'hA5}, 1'b1, FLAW_NONE);
    queue_record('{8'h3C}, 1'b1, FLAW_DATA_BIT);
    queue_record('{8'h81}, 1'b1, FLAW_CHECK_BIT);
    queue_record('{8'h5A}, 1'b1, FLAW_PARITY_BIT);
    queue_record('{8'h00}, 1'b1, FLAW_PAST_DATA);
    queue_record('{8'hFF}, 1'b1, FLAW_DOUBLE);
    queue_record('{8'h12, 8'h34}, 1'b1, FLAW_DATA_BIT);
    queue_record('{8'hFF, 8'h00, 8'hC3}, 1'b0, FLAW_NONE);
    queue_record('{8'h00, 8'h00}, 1'b1, FLAW_GARBAGE);

    // Random records: mostly short, some at the length limit, some past it
    records = 0;
    while (pending_bytes.size() < RAND_BYTES || records < MIN_RECORDS) begin
      sel = $urandom_range(99);
      if (sel < 65)      len = $urandom_range(6, 1);
      else if (sel < 85) len = $urandom_range(40, 7);
      else if (sel < 93) len = $urandom_range(MAX_BYTES, MAX_BYTES - 1);
      else               len = $urandom_range(MAX_BYTES + 6, MAX_BYTES + 1);
      body.delete();
      for (int k = 0; k < len; k++) body.push_back(8'($urandom_range(255)));
      dec = ($urandom_range(99) < 65);
      sel = $urandom_range(99);
      if (sel < 20)      flaw = FLAW_NONE;
      else if (sel < 45) flaw = FLAW_DATA_BIT;
      else if (sel < 55) flaw = FLAW_CHECK_BIT;
      else if (sel < 62) flaw = FLAW_PARITY_BIT;
      else if (sel < 72) flaw = FLAW_PAST_DATA;
      else if (sel < 88) flaw = FLAW_DOUBLE;
      else               flaw = FLAW_GARBAGE;
      queue_record(body, dec, flaw);
      records++;
    end
    total_bytes = pending_bytes.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: all bytes in, all reports out, then a wait for stray output
    while (pending_bytes.size() != 0 || in_if.valid || predicted_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[hamming_secded_record_codec] OK");
    end else begin
      $display("[hamming_secded_record_codec] ERROR");
    end
    $finish;
  end

endmodule
